// ===== rtl/core/gsfr_pkg.sv =====
// Shared types and constants for the gas sensor frame reader.
`timescale 1ns / 1ps
`default_nettype none
package gsfr_pkg;

   localparam int unsigned FRAME_LENGTH = 9;
   localparam int unsigned POS_W        = 4;
   localparam int unsigned CONC_W       = 17;
   localparam int unsigned BYTE_W       = 8;
   localparam int unsigned BIAS_W       = 16;
   localparam int unsigned SUM_W        = CONC_W + 1;

   localparam logic [BYTE_W-1:0] START_BYTE   = 8'hFF;
   localparam logic [BYTE_W-1:0] READ_COMMAND = 8'h86;

   localparam logic [POS_W-1:0] POS_COMMAND = 4'd1;
   localparam logic [POS_W-1:0] POS_HIGH    = 4'd2;
   localparam logic [POS_W-1:0] POS_LOW     = 4'd3;
   localparam logic [POS_W-1:0] POS_LAST    = POS_W'(FRAME_LENGTH - 1);

   typedef enum logic [1:0] {
      STATUS_INCOMPLETE  = 2'd0,
      STATUS_COMPLETE    = 2'd1,
      STATUS_BAD_COMMAND = 2'd2
   } status_type;

   typedef struct packed {
      status_type         status;
      logic [CONC_W-1:0]  concentration_tenths;
      logic [BYTE_W-1:0]  frame_checksum;
   } result_type;

endpackage
`default_nettype wire

// ===== rtl/core/gsfr_parser.sv =====
// Frame position tracking, value capture and biased concentration for one beat.
`timescale 1ns / 1ps
`default_nettype none
module gsfr_parser (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          accept,
   input  wire logic [gsfr_pkg::BYTE_W-1:0]   rx_byte,
   input  wire logic signed [gsfr_pkg::BIAS_W-1:0] bias_tenths,
   output gsfr_pkg::result_type               result
);
   import gsfr_pkg::*;

   logic              in_frame_ff, in_frame_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [BYTE_W-1:0] high_ff, high_in;
   logic [BYTE_W-1:0] low_ff, low_in;
   logic signed [SUM_W-1:0] sum;

   assign sum = $signed({2'b00, high_ff, low_ff}) + SUM_W'(bias_tenths);

   always_comb begin
      in_frame_in = in_frame_ff;
      pos_in      = pos_ff;
      high_in     = high_ff;
      low_in      = low_ff;
      result.status               = STATUS_INCOMPLETE;
      result.concentration_tenths = '0;
      result.frame_checksum       = '0;
      if (rx_byte == START_BYTE) begin
         in_frame_in = 1'b1;
         pos_in      = POS_COMMAND;
      end else if (in_frame_ff) begin
         if (pos_ff == POS_COMMAND) begin
            if (rx_byte != READ_COMMAND) begin
               result.status = STATUS_BAD_COMMAND;
               in_frame_in   = 1'b0;
               pos_in        = '0;
            end else begin
               pos_in = pos_ff + 1'b1;
            end
         end else if (pos_ff >= POS_LAST) begin
            result.status               = STATUS_COMPLETE;
            result.concentration_tenths = sum[SUM_W-1] ? '0 : sum[CONC_W-1:0];
            result.frame_checksum       = rx_byte;
            in_frame_in                 = 1'b0;
            pos_in                      = '0;
         end else begin
            if (pos_ff == POS_HIGH) begin
               high_in = rx_byte;
            end
            if (pos_ff == POS_LOW) begin
               low_in = rx_byte;
            end
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         pos_ff      <= '0;
      end else if (accept) begin
         in_frame_ff <= in_frame_in;
         pos_ff      <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         high_ff <= high_in;
         low_ff  <= low_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/gsfr_out_buf.sv =====
// Result register with a skid stage between the parser and the result channel.
`timescale 1ns / 1ps
`default_nettype none
module gsfr_out_buf (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire gsfr_pkg::result_type push_data,
   output logic                      push_ready,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output gsfr_pkg::result_type      out_data
);
   import gsfr_pkg::*;

   logic       main_valid_ff, skid_valid_ff;
   result_type main_ff, skid_ff;

   assign push_ready = !skid_valid_ff;
   assign out_valid  = main_valid_ff;
   assign out_data   = main_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_ready || !main_valid_ff) begin
         if (skid_valid_ff) begin
            main_valid_ff <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            main_valid_ff <= push;
         end
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready || !main_valid_ff) begin
         main_ff <= skid_valid_ff ? skid_ff : push_data;
      end else if (push) begin
         skid_ff <= push_data;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/gas_sensor_frame_reader_core.sv =====
// Top level of the gas sensor frame reader: bias register, parser and result buffer.
// Each accepted byte beat yields a result beat, which is registered in the result buffer.
// Throughput: one byte beat per cycle; the skid stage holds one result while
// the result channel stalls, and req_ready drops only when both stages are full.
// Reset: synchronous, active high; clears frame hunting state, buffered
// results and the bias register (to zero).
`timescale 1ns / 1ps
`default_nettype none
module gas_sensor_frame_reader_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [gsfr_pkg::BYTE_W-1:0]         req_rx_byte,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [1:0]                               rsp_status,
   output logic [gsfr_pkg::CONC_W-1:0]              rsp_concentration_tenths,
   output logic [gsfr_pkg::BYTE_W-1:0]              rsp_frame_checksum,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic signed [gsfr_pkg::BIAS_W-1:0]  csr_bias_tenths
);
   import gsfr_pkg::*;

   logic signed [BIAS_W-1:0] bias_ff;
   logic                     accept;
   result_type               parse_result;
   result_type               out_data;

   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         bias_ff <= '0;
      end else if (csr_valid) begin
         bias_ff <= csr_bias_tenths;
      end
   end

   gsfr_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .rx_byte     (req_rx_byte),
      .bias_tenths (bias_ff),
      .result      (parse_result)
   );

   gsfr_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_data  (parse_result),
      .push_ready (req_ready),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_data   (out_data)
   );

   assign rsp_status               = out_data.status;
   assign rsp_concentration_tenths = out_data.concentration_tenths;
   assign rsp_frame_checksum       = out_data.frame_checksum;

endmodule
`default_nettype wire
